FILE: design/pcfb_pkg.sv
// shared constants, codes and types of the pixel compositor framebuffer
`default_nettype none

package pcfb_pkg;

    // framebuffer geometry
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int FB_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(FB_DEPTH);

    // pixel and field widths
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int PIX_W    = CHAN_W * NUM_CHAN;
    localparam int COORD_W  = 16;
    localparam int CFG_W    = 10;
    localparam int ALPHA_W  = 10;
    localparam int INTEN_W  = 16;
    localparam int ACT_W    = 2;

    // stream word layout
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 24;

    // register port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0]  CANVAS_RST = CFG_W'(512);
    localparam logic [CHAN_W-1:0] CHAN_MAX   = {CHAN_W{1'b1}};

    typedef enum logic [ACT_W-1:0] {
        ACT_READ,
        ACT_SET,
        ACT_BLEND,
        ACT_GLOW
    } action_t;

    typedef enum logic {
        REG_CANVAS_WIDTH,
        REG_CANVAS_HEIGHT
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_WRITE
    } fb_state_t;

    // control from the sequencer to the pixel arithmetic
    typedef struct packed {
        logic load;
        logic blend_sel;
    } rop_ctrl_t;

endpackage

`default_nettype wire

FILE: design/pcfb_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module pcfb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/pcfb_rop.sv
// per-channel alpha blend and saturating additive glow, one product stage
`default_nettype none

module pcfb_rop (
    input  wire logic                            aclk,
    input  wire pcfb_pkg::rop_ctrl_t             ctrl,
    input  wire logic [pcfb_pkg::PIX_W-1:0]      old_pix,
    input  wire logic [pcfb_pkg::PIX_W-1:0]      src_pix,
    input  wire logic [pcfb_pkg::CHAN_W-1:0]     alpha,
    input  wire logic [pcfb_pkg::INTEN_W-1:0]    intensity,
    output      logic [pcfb_pkg::PIX_W-1:0]      new_pix
);
    import pcfb_pkg::*;

    localparam int DIFF_W  = CHAN_W + 1;
    localparam int BPROD_W = DIFF_W + CHAN_W + 1;
    localparam int GPROD_W = CHAN_W + INTEN_W;
    localparam int RECIP_W = BPROD_W + CHAN_W + 1;
    localparam int Q_W     = CHAN_W + 1;
    localparam int BRES_W  = CHAN_W + 3;
    localparam int GSUM_W  = GPROD_W - CHAN_W + 2;

    logic [PIX_W-1:0] old_reg;
    logic             blend_sel_reg;

    // shared operand registers
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            old_reg       <= old_pix;
            blend_sel_reg <= ctrl.blend_sel;
        end
    end

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
        logic        [CHAN_W-1:0]  old_c;
        logic        [CHAN_W-1:0]  src_c;
        logic signed [DIFF_W-1:0]  diff;
        logic signed [BPROD_W-1:0] bprod_next;
        logic signed [BPROD_W-1:0] bprod_reg;
        logic        [GPROD_W-1:0] gprod_next;
        logic        [GPROD_W-1:0] gprod_reg;
        logic signed [BPROD_W-1:0] dsum;
        logic                      neg;
        logic        [BPROD_W-1:0] mag;
        logic        [RECIP_W-1:0] recip;
        logic        [Q_W-1:0]     q0;
        logic        [BPROD_W-1:0] rem;
        logic        [Q_W-1:0]     quot;
        logic signed [BRES_W-1:0]  bres;
        logic        [CHAN_W-1:0]  bout;
        logic        [GPROD_W:0]   gr;
        logic        [GSUM_W-1:0]  gsum;
        logic        [CHAN_W-1:0]  gout;

        assign old_c = old_pix[c*CHAN_W +: CHAN_W];
        assign src_c = src_pix[c*CHAN_W +: CHAN_W];

        // products: (new - old) * alpha and ch * intensity
        always_comb begin
            diff       = signed'({1'b0, src_c}) - signed'({1'b0, old_c});
            bprod_next = BPROD_W'(diff) * signed'(BPROD_W'(alpha));
            gprod_next = GPROD_W'(src_c) * GPROD_W'(intensity);
        end

        always_ff @(posedge aclk) begin
            if (ctrl.load) begin
                bprod_reg <= bprod_next;
                gprod_reg <= gprod_next;
            end
        end

        // blend: add 127, then divide by 255 truncating toward zero, via *257 >> 16 and one correction
        always_comb begin
            dsum  = bprod_reg + BPROD_W'(127);
            neg   = dsum[BPROD_W-1];
            mag   = neg ? BPROD_W'(-dsum) : BPROD_W'(dsum);
            recip = RECIP_W'({mag, {CHAN_W{1'b0}}}) + RECIP_W'(mag);
            q0    = recip[2*CHAN_W +: Q_W];
            rem   = mag - (BPROD_W'({q0, {CHAN_W{1'b0}}}) - BPROD_W'(q0));
            quot  = (rem >= BPROD_W'(CHAN_MAX)) ? q0 + Q_W'(1) : q0;
            bres  = neg ? signed'(BRES_W'(old_reg[c*CHAN_W +: CHAN_W])) - signed'(BRES_W'(quot))
                        : signed'(BRES_W'(old_reg[c*CHAN_W +: CHAN_W])) + signed'(BRES_W'(quot));
            if (bres < 0) begin
                bout = '0;
            end else if (bres > signed'(BRES_W'(CHAN_MAX))) begin
                bout = CHAN_MAX;
            end else begin
                bout = bres[CHAN_W-1:0];
            end
        end

        // glow: round half up, add, saturate
        always_comb begin
            gr   = (GPROD_W + 1)'(gprod_reg) + (GPROD_W + 1)'(128);
            gsum = GSUM_W'(gr[GPROD_W:CHAN_W]) + GSUM_W'(old_reg[c*CHAN_W +: CHAN_W]);
            gout = (gsum > GSUM_W'(CHAN_MAX)) ? CHAN_MAX : gsum[CHAN_W-1:0];
        end

        assign new_pix[c*CHAN_W +: CHAN_W] = blend_sel_reg ? bout : gout;
    end

endmodule

`default_nettype wire

FILE: design/pixel_compositor_framebuffer.sv
// top level: stream and register ports, sequencer, frame memory and pixel arithmetic
`default_nettype none

// Raster operation unit over a 512 x 512 frame of 24-bit 0xRRGGBB pixels held in one
// synchronous ram (pixel (x, y) at y * 512 + x). After reset a clearing pass writes zero
// to every pixel, one per cycle; s_tready stays low during it while register writes are
// taken as usual. Each set, blend or glow word then goes through accept (ram read issued),
// fetch (old pixel in hand, products registered) and write-back; a read word skips
// write-back. The single read-modify-write sequence means a write-back never overlaps
// the next word's read. A read returns one m_ word; it waits in fetch if the output
// register is still full. Positions outside the canvas are not written and read back
// as color 0 with read_valid 0.
module pixel_compositor_framebuffer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input words
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    // pos_x[15:0], pos_y[31:16], pixel_color[55:32], blend_alpha[65:56],
    // glow_intensity[81:66], zero fill[87:82]
    input  wire logic [pcfb_pkg::S_DATA_W-1:0]     s_tdata,
    // action[1:0]
    input  wire logic [pcfb_pkg::ACT_W-1:0]        s_tuser,
    // result words
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // read_color[23:0]
    output      logic [pcfb_pkg::M_DATA_W-1:0]     m_tdata,
    // read_valid[0]
    output      logic [0:0]                        m_tuser,
    // register port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pcfb_pkg::APB_AW-1:0]       paddr,
    input  wire logic [pcfb_pkg::APB_DW-1:0]       pwdata,
    output      logic [pcfb_pkg::APB_DW-1:0]       prdata,
    output      logic                              pready
);
    import pcfb_pkg::*;

    localparam int CMP_W = 32;

    fb_state_t state_reg, state_next;

    logic [CFG_W-1:0]   width_reg, height_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg;

    action_t            op_reg;
    logic [PIX_W-1:0]   color_reg;
    logic [CHAN_W-1:0]  alpha_reg;
    logic [INTEN_W-1:0] inten_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               inside_reg;
    logic               wr_en_reg;

    logic               m_tvalid_reg;
    logic [PIX_W-1:0]   m_color_reg;
    logic               m_flag_reg;

    // unpacked input fields
    action_t                  in_act;
    logic signed [COORD_W-1:0] in_x, in_y;
    logic [PIX_W-1:0]         in_color;
    logic signed [ALPHA_W-1:0] in_alpha;
    logic [INTEN_W-1:0]       in_inten;

    logic [CMP_W-1:0]   w_eff, h_eff;
    logic               in_inside;
    logic [ADDR_W-1:0]  in_addr;
    logic               alpha_pos;
    logic [CHAN_W-1:0]  alpha_clamp;
    logic               in_wr_en;

    logic               accept;
    logic               out_free;
    logic               out_load;
    logic               cfg_wr;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [PIX_W-1:0]   ram_wdata, ram_rdata;
    rop_ctrl_t          rop_ctrl;
    logic [PIX_W-1:0]   rop_pix;

    // field unpacking
    assign in_act   = action_t'(s_tuser);
    assign in_x     = signed'(s_tdata[15:0]);
    assign in_y     = signed'(s_tdata[31:16]);
    assign in_color = s_tdata[55:32];
    assign in_alpha = signed'(s_tdata[65:56]);
    assign in_inten = s_tdata[81:66];

    // canvas check and pixel address
    always_comb begin
        w_eff = (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : CMP_W'(width_reg);
        h_eff = (CMP_W'(height_reg) > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT)
                                                           : CMP_W'(height_reg);
        in_inside = !in_x[COORD_W-1] && !in_y[COORD_W-1]
                    && (CMP_W'(unsigned'(in_x)) < w_eff)
                    && (CMP_W'(unsigned'(in_y)) < h_eff);
        in_addr = ADDR_W'(CMP_W'(unsigned'(in_y)) * CMP_W'(MAX_WIDTH)
                          + CMP_W'(unsigned'(in_x)));
    end

    // alpha clamp and whether the word changes the frame
    always_comb begin
        alpha_pos   = !in_alpha[ALPHA_W-1] && (in_alpha != '0);
        alpha_clamp = in_alpha[ALPHA_W-2] ? CHAN_MAX : in_alpha[CHAN_W-1:0];
        unique case (in_act)
            ACT_READ:  in_wr_en = 1'b0;
            ACT_SET:   in_wr_en = in_inside;
            ACT_BLEND: in_wr_en = in_inside && alpha_pos;
            ACT_GLOW:  in_wr_en = in_inside && (in_inten != '0);
        endcase
    end

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == ADDR_W'(FB_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (op_reg != ACT_READ) begin
                    state_next = ST_WRITE;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WRITE: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready           = 1'b0;
        ram_re             = 1'b0;
        ram_we             = 1'b0;
        ram_waddr          = addr_reg;
        ram_wdata          = (op_reg == ACT_SET) ? color_reg : rop_pix;
        rop_ctrl.load      = 1'b0;
        rop_ctrl.blend_sel = (op_reg == ACT_BLEND);
        out_load           = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                ram_re   = s_tvalid;
            end
            ST_FETCH: begin
                rop_ctrl.load = 1'b1;
                out_load      = (op_reg == ACT_READ) && out_free;
            end
            ST_WRITE: begin
                ram_we = wr_en_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
        end
    end

    // captured word
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= in_act;
            color_reg  <= in_color;
            alpha_reg  <= alpha_clamp;
            inten_reg  <= in_inten;
            addr_reg   <= in_addr;
            inside_reg <= in_inside;
            wr_en_reg  <= in_wr_en;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_color_reg <= inside_reg ? ram_rdata : '0;
            m_flag_reg  <= inside_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_color_reg;
    assign m_tuser[0] = m_flag_reg;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CANVAS_RST;
            height_reg <= CANVAS_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(paddr[2]))
                REG_CANVAS_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_CANVAS_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[2]))
            REG_CANVAS_WIDTH:  prdata = APB_DW'(width_reg);
            REG_CANVAS_HEIGHT: prdata = APB_DW'(height_reg);
        endcase
    end

    // frame memory
    pcfb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FB_DEPTH)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // pixel arithmetic
    pcfb_rop u_rop (
        .aclk      (aclk),
        .ctrl      (rop_ctrl),
        .old_pix   (ram_rdata),
        .src_pix   (color_reg),
        .alpha     (alpha_reg),
        .intensity (inten_reg),
        .new_pix   (rop_pix)
    );

    // an accepted word is always in fetch on the next cycle
    a_accept_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_FETCH))
        else $error("accepted word did not move to fetch");

    // the frame is written back only right after a fetch, or by the clearing pass
    a_write_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && (state_reg != ST_CLEAR)) |-> ($past(state_reg) == ST_FETCH))
        else $error("frame write without a preceding fetch");

    // the clearing pass writes only zero
    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (ram_we && (ram_wdata == '0)))
        else $error("clearing pass wrote a nonzero pixel");

    // a read outside the canvas reports color zero
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("outside read returned a nonzero color");

    // a result is loaded only into a free output register
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending result");

endmodule

`default_nettype wire
